// ===== rtl/core/fat_chain_file_engine_macros.svh =====
// Assertion helpers shared by the engine modules.
// Each expects clk_i and rst_ni in the scope where it is used.
`ifndef FAT_CHAIN_FILE_ENGINE_MACROS_SVH
`define FAT_CHAIN_FILE_ENGINE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FCE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FCE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fce_pkg.sv =====
package fce_pkg;

  // Default geometry
  localparam int unsigned DefNumBlocks  = 256;
  localparam int unsigned DefBlockBytes = 64;
  localparam int unsigned DefNumFiles   = 16;

  // Fixed field widths
  localparam int unsigned SizeW = 15;
  localparam int unsigned PosW  = 16;

  // Request codes
  localparam logic [2:0] REQ_CLEAR = 3'd0;
  localparam logic [2:0] REQ_OPEN  = 3'd1;
  localparam logic [2:0] REQ_WRITE = 3'd2;
  localparam logic [2:0] REQ_READ  = 3'd3;
  localparam logic [2:0] REQ_SEEK  = 3'd4;

  // Seek origins
  localparam logic [1:0] ORG_START = 2'd0;
  localparam logic [1:0] ORG_CUR   = 2'd1;
  localparam logic [1:0] ORG_END   = 2'd2;
  localparam logic [1:0] ORG_BAD   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_FREE = 3'd1;
  localparam logic [2:0] ST_BAD_ORG = 3'd2;
  localparam logic [2:0] ST_BAD_POS = 3'd3;
  localparam logic [2:0] ST_EOF     = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic       latch;       // capture the accepted item
    logic       clear_file;  // reset one file entry
    logic       open_set;    // load handle from the file entry
    logic       alloc;       // take the lowest free block
    logic       tail_rd;     // address link table at the tail
    logic       tail_next;   // tail moves along its link
    logic       tail_link;   // link tail to the new block
    logic       byte_wr;     // store write byte
    logic       byte_cap;    // capture byte read
    logic       step;        // advance position by one byte
    logic       next_set;    // current block follows its link
    logic       seek_init;   // load seek target
    logic       seek_sub;    // one block off the remaining target
    logic       seek_fin;    // remainder becomes the block offset
    logic       set_status;
    logic [2:0] status;
    logic       finish;      // load output register
  } fce_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] req;
    logic       idx_ok;
    logic       cur_valid;
    logic       start_valid;
    logic       alloc_full;
    logic       link_end;
    logic       off_last;
    logic       rd_ok;
    logic       origin_bad;
    logic       target_bad;
    logic       rem_ge;
  } fce_stat_t;

endpackage

// ===== rtl/core/fce_ram.sv =====
module fce_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word registered
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/fce_dp.sv =====
`include "fat_chain_file_engine_macros.svh"

module fce_dp import fce_pkg::*; #(
  parameter int unsigned NUM_BLOCKS  = DefNumBlocks,
  parameter int unsigned BLOCK_BYTES = DefBlockBytes,
  parameter int unsigned NUM_FILES   = DefNumFiles
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fce_cmd_t          cmd_i,
  output fce_stat_t         stat_o,
  input  logic [2:0]        req_i,
  input  logic [3:0]        idx_i,
  input  logic [7:0]        wdata_i,
  input  logic [15:0]       offset_i,
  input  logic [1:0]        origin_i,
  output logic [2:0]        status_o,
  output logic [7:0]        rdata_o,
  output logic [SizeW-1:0]  position_o,
  output logic [SizeW-1:0]  size_o
);

  localparam int unsigned BW      = $clog2(NUM_BLOCKS);
  localparam int unsigned OW      = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int unsigned FAW     = (NUM_FILES > 1) ? $clog2(NUM_FILES) : 1;
  localparam int unsigned Bytes   = NUM_BLOCKS * BLOCK_BYTES;
  localparam int unsigned BAW     = $clog2(Bytes);
  localparam int unsigned SizeCap = (Bytes < 32767) ? Bytes : 32767;
  localparam int unsigned FEW     = 1 + BW + SizeW;

  // Latched request
  logic [2:0]  req_q;
  logic [3:0]  idx_q;
  logic [7:0]  wdata_q;
  logic [15:0] offset_q;
  logic [1:0]  origin_q;

  // Handle and open file cache
  logic [FAW-1:0]   open_q;
  logic             ostart_v_q;
  logic [BW-1:0]    ostart_q;
  logic [SizeW-1:0] osize_q;
  logic             cur_v_q;
  logic [BW-1:0]    cur_q;
  logic [PosW-1:0]  pos_q;
  logic [OW-1:0]    off_q;

  // Work registers
  logic [BW:0]      alloc_q;
  logic [BW-1:0]    tail_q;
  logic [SizeW-1:0] rem_q;
  logic [NUM_FILES-1:0] fvalid_q;
  logic             fwb_q;
  logic [2:0]       status_q;
  logic [7:0]       rdata_q;

  // Output register
  logic [2:0]       out_status_q;
  logic [7:0]       out_rdata_q;
  logic [SizeW-1:0] out_pos_q;
  logic [SizeW-1:0] out_size_q;

  logic [FAW-1:0] fidx;
  logic           idx_ok;
  assign fidx   = FAW'(idx_q);
  assign idx_ok = 32'(idx_q) < NUM_FILES;

  // File table: {has start, start block, size}
  logic           f_we;
  logic [FAW-1:0] f_waddr;
  logic [FEW-1:0] f_wdata;
  logic [FEW-1:0] f_rdata;
  logic           frd_v;
  logic [BW-1:0]  frd_blk;
  logic [SizeW-1:0] frd_size;

  assign f_we    = cmd_i.clear_file || fwb_q;
  assign f_waddr = cmd_i.clear_file ? fidx : open_q;
  assign f_wdata = cmd_i.clear_file ? '0 : {ostart_v_q, ostart_q, osize_q};

  fce_ram #(.Width(FEW), .Depth(NUM_FILES)) u_file_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .raddr_i (fidx),
    .rdata_o (f_rdata)
  );

  // An entry never written reads as no block, size zero
  always_comb begin
    {frd_v, frd_blk, frd_size} = f_rdata;
    if (!fvalid_q[fidx]) begin
      frd_v    = 1'b0;
      frd_size = '0;
    end
  end

  // Link table: {end of chain, next block}; blocks at or above alloc_q are free
  logic          l_we;
  logic [BW-1:0] l_waddr;
  logic [BW:0]   l_wdata;
  logic [BW-1:0] l_raddr;
  logic [BW:0]   l_rdata;

  assign l_we    = cmd_i.alloc || cmd_i.tail_link;
  assign l_waddr = cmd_i.alloc ? alloc_q[BW-1:0] : tail_q;
  assign l_wdata = cmd_i.alloc ? {1'b1, {BW{1'b0}}} : {1'b0, cur_q};
  assign l_raddr = cmd_i.tail_rd ? tail_q : cur_q;

  fce_ram #(.Width(BW + 1), .Depth(NUM_BLOCKS)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  // Byte store
  logic [BAW-1:0] b_addr;
  logic [7:0]     b_rdata;
  assign b_addr = BAW'(32'(cur_q) * BLOCK_BYTES) + BAW'(off_q);

  fce_ram #(.Width(8), .Depth(Bytes)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.byte_wr),
    .waddr_i (b_addr),
    .wdata_i (wdata_q),
    .raddr_i (b_addr),
    .rdata_o (b_rdata)
  );

  // Seek target
  logic signed [17:0] pos_s, size_s, off_s, tgt;
  always_comb begin
    pos_s  = $signed({2'b00, pos_q});
    size_s = $signed({3'b000, osize_q});
    off_s  = $signed({{2{offset_q[15]}}, offset_q});
    case (origin_q)
      ORG_CUR: tgt = pos_s + off_s;
      ORG_END: tgt = size_s + off_s;
      default: tgt = off_s;
    endcase
  end

  logic off_last;
  assign off_last = (off_q == OW'(BLOCK_BYTES - 1));

  // Status to controller
  always_comb begin
    stat_o.req         = req_q;
    stat_o.idx_ok      = idx_ok;
    stat_o.cur_valid   = cur_v_q;
    stat_o.start_valid = ostart_v_q;
    stat_o.alloc_full  = (alloc_q == (BW + 1)'(NUM_BLOCKS));
    stat_o.link_end    = l_rdata[BW];
    stat_o.off_last    = off_last;
    stat_o.rd_ok       = cur_v_q && (pos_q < {1'b0, osize_q});
    stat_o.origin_bad  = (origin_q == ORG_BAD);
    stat_o.target_bad  = (tgt < 18'sd0) || (tgt > size_s);
    stat_o.rem_ge      = 32'(rem_q) >= BLOCK_BYTES;
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q    <= req_i;
      idx_q    <= idx_i;
      wdata_q  <= wdata_i;
      offset_q <= offset_i;
      origin_q <= origin_i;
      status_q <= ST_OK;
      rdata_q  <= '0;
    end
    if (cmd_i.set_status) begin
      status_q <= cmd_i.status;
    end
    if (cmd_i.byte_cap) begin
      rdata_q <= b_rdata;
    end
    if (cmd_i.alloc) begin
      tail_q <= ostart_q;
    end else if (cmd_i.tail_next) begin
      tail_q <= l_rdata[BW-1:0];
    end
    if (cmd_i.seek_init) begin
      rem_q <= tgt[SizeW-1:0];
    end else if (cmd_i.seek_sub) begin
      rem_q <= rem_q - SizeW'(BLOCK_BYTES);
    end
    if (cmd_i.finish) begin
      out_status_q <= status_q;
      out_rdata_q  <= rdata_q;
      out_pos_q    <= pos_q[SizeW-1:0];
      out_size_q   <= osize_q;
    end
  end

  // Handle, cache and allocation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q     <= '0;
      ostart_v_q <= 1'b0;
      ostart_q   <= '0;
      osize_q    <= '0;
      cur_v_q    <= 1'b0;
      cur_q      <= '0;
      pos_q      <= '0;
      off_q      <= '0;
      alloc_q    <= '0;
      fvalid_q   <= '0;
      fwb_q      <= 1'b0;
    end else begin
      fwb_q <= cmd_i.step && (req_q == REQ_WRITE);
      // Mark the open entry written once the cache is stored back
      if (fwb_q) begin
        fvalid_q[open_q] <= 1'b1;
      end
      if (cmd_i.clear_file) begin
        fvalid_q[fidx] <= 1'b1;
        if (fidx == open_q) begin
          ostart_v_q <= 1'b0;
          osize_q    <= '0;
          cur_v_q    <= 1'b0;
          pos_q      <= '0;
          off_q      <= '0;
        end
      end
      if (cmd_i.open_set) begin
        open_q     <= fidx;
        ostart_v_q <= frd_v;
        ostart_q   <= frd_blk;
        osize_q    <= frd_size;
        cur_v_q    <= frd_v;
        cur_q      <= frd_blk;
        pos_q      <= '0;
        off_q      <= '0;
      end
      if (cmd_i.alloc) begin
        alloc_q <= alloc_q + 1'b1;
        cur_v_q <= 1'b1;
        cur_q   <= alloc_q[BW-1:0];
        if (!ostart_v_q) begin
          ostart_v_q <= 1'b1;
          ostart_q   <= alloc_q[BW-1:0];
        end
      end
      if (cmd_i.step) begin
        pos_q <= pos_q + 1'b1;
        off_q <= off_last ? '0 : off_q + 1'b1;
        if (req_q == REQ_WRITE && osize_q < SizeW'(SizeCap)) begin
          osize_q <= osize_q + 1'b1;
        end
      end
      if (cmd_i.next_set) begin
        if (l_rdata[BW]) begin
          cur_v_q <= 1'b0;
        end else begin
          cur_q <= l_rdata[BW-1:0];
        end
      end
      if (cmd_i.seek_init) begin
        pos_q   <= {1'b0, tgt[SizeW-1:0]};
        cur_v_q <= ostart_v_q;
        cur_q   <= ostart_q;
      end
      if (cmd_i.seek_fin) begin
        off_q <= OW'(rem_q);
      end
    end
  end

  assign status_o   = out_status_q;
  assign rdata_o    = out_rdata_q;
  assign position_o = out_pos_q;
  assign size_o     = out_size_q;

  `FCE_ASSERT_IMP(a_cur_allocated, cur_v_q, {1'b0, cur_q} < alloc_q, "current block not allocated")
  `FCE_ASSERT_IMP(a_off_in_block, 1'b1, 32'(off_q) < BLOCK_BYTES, "block offset out of range")
  `FCE_ASSERT_IMP(a_alloc_has_room, cmd_i.alloc, !stat_o.alloc_full, "allocation with no free block")

endmodule

// ===== rtl/core/fce_ctrl.sv =====
`include "fat_chain_file_engine_macros.svh"

module fce_ctrl import fce_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  fce_stat_t stat_i,
  output fce_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_OPEN, S_ALLOC, S_TAIL_RD, S_TAIL_CHK, S_WRITE,
    S_READ, S_READ_CAP, S_NEXT, S_SEEK, S_SEEK_SET, S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode commands and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_d = S_FINISH;
        unique case (stat_i.req) inside
          REQ_CLEAR, REQ_OPEN: begin
            if (!stat_i.idx_ok) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_POS;
            end else if (stat_i.req == REQ_CLEAR) begin
              cmd_o.clear_file = 1'b1;
            end else begin
              state_d = S_OPEN;
            end
          end
          REQ_WRITE: begin
            if (stat_i.cur_valid) begin
              state_d = S_WRITE;
            end else if (stat_i.alloc_full) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_NO_FREE;
            end else begin
              state_d = S_ALLOC;
            end
          end
          REQ_READ: begin
            if (stat_i.rd_ok) begin
              state_d = S_READ;
            end else begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_EOF;
            end
          end
          REQ_SEEK: begin
            if (stat_i.origin_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_ORG;
            end else if (stat_i.target_bad) begin
              cmd_o.set_status = 1'b1;
              cmd_o.status     = ST_BAD_POS;
            end else begin
              cmd_o.seek_init = 1'b1;
              state_d         = S_SEEK;
            end
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_OPEN: begin
        cmd_o.open_set = 1'b1;
        state_d        = S_FINISH;
      end
      S_ALLOC: begin
        cmd_o.alloc = 1'b1;
        state_d     = stat_i.start_valid ? S_TAIL_RD : S_WRITE;
      end
      S_TAIL_RD: begin
        cmd_o.tail_rd = 1'b1;
        state_d       = S_TAIL_CHK;
      end
      S_TAIL_CHK: begin
        if (stat_i.link_end) begin
          cmd_o.tail_link = 1'b1;
          state_d         = S_WRITE;
        end else begin
          cmd_o.tail_next = 1'b1;
          state_d         = S_TAIL_RD;
        end
      end
      S_WRITE: begin
        cmd_o.byte_wr = 1'b1;
        cmd_o.step    = 1'b1;
        state_d       = stat_i.off_last ? S_NEXT : S_FINISH;
      end
      S_READ: begin
        state_d = S_READ_CAP;
      end
      S_READ_CAP: begin
        cmd_o.byte_cap = 1'b1;
        cmd_o.step     = 1'b1;
        state_d        = stat_i.off_last ? S_NEXT : S_FINISH;
      end
      S_NEXT: begin
        cmd_o.next_set = 1'b1;
        state_d        = S_FINISH;
      end
      S_SEEK: begin
        if (stat_i.rem_ge) begin
          cmd_o.seek_sub = 1'b1;
          state_d        = stat_i.cur_valid ? S_SEEK_SET : S_SEEK;
        end else begin
          cmd_o.seek_fin = 1'b1;
          state_d        = S_FINISH;
        end
      end
      S_SEEK_SET: begin
        cmd_o.next_set = 1'b1;
        state_d        = S_SEEK;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FCE_ASSERT_NXT(a_accept_leaves_idle, in_valid_i && in_ready_o, state_q == S_DISPATCH, "accepted item not dispatched")
  `FCE_ASSERT_IMP(a_finish_slot_free, cmd_o.finish, !out_valid_q || out_ready_i, "result overwrites a pending result")
  `FCE_ASSERT_NXT(a_finish_sets_valid, cmd_o.finish, out_valid_q, "finished result not presented")

endmodule

// ===== rtl/core/fat_chain_file_engine.sv =====
// Channel   Dir  tdata                                           tuser
// s_axis    in   file_index, write_data, seek_offset (32 bits)   req_type, seek_origin
// m_axis    out  read_data, position, file_size (40 bits)        status
//
// One request at a time: s_axis is ready only while idle. A write into a missing block first
// allocates one and walks an existing chain to its tail to link it; a seek restarts at the
// first block and steps along the chain block by block. Link table and byte store are RAMs
// with registered reads.
// Reset is asynchronous and active low; the byte store is not cleared.
// A stalled m_axis holds its result; the next item is still accepted and waits at the end.
module fat_chain_file_engine import fce_pkg::*; #(
  parameter int unsigned NUM_BLOCKS  = DefNumBlocks,
  parameter int unsigned BLOCK_BYTES = DefBlockBytes,
  parameter int unsigned NUM_FILES   = DefNumFiles
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] file_index, [11:4] write_data, [27:12] seek_offset, [31:28] zero
  input  logic [31:0] s_axis_tdata_i,
  // [2:0] req_type, [4:3] seek_origin
  input  logic [4:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] read_data, [22:8] position, [37:23] file_size, [39:38] zero
  output logic [39:0] m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]  m_axis_tuser_o
);

  fce_cmd_t         cmd;
  fce_stat_t        stat;
  logic [7:0]       rdata;
  logic [SizeW-1:0] position;
  logic [SizeW-1:0] file_size;

  fce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  fce_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_FILES   (NUM_FILES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .req_i      (s_axis_tuser_i[2:0]),
    .idx_i      (s_axis_tdata_i[3:0]),
    .wdata_i    (s_axis_tdata_i[11:4]),
    .offset_i   (s_axis_tdata_i[27:12]),
    .origin_i   (s_axis_tuser_i[4:3]),
    .status_o   (m_axis_tuser_o),
    .rdata_o    (rdata),
    .position_o (position),
    .size_o     (file_size)
  );

  // Pack result fields
  assign m_axis_tdata_o = {2'b00, file_size, position, rdata};

endmodule

// ===== bench/fat_chain_file_engine_tb.sv =====
`timescale 1ns / 100ps

module fat_chain_file_engine_tb;
  import fce_pkg::*;

  localparam int NBlk = 256;
  localparam int BBytes = 64;
  localparam int NFile = 16;
  localparam int SizeCap = (NBlk * BBytes < 32767) ? NBlk * BBytes : 32767;
  localparam int NoBlk = -1;
  localparam int LinkFree = -1;
  localparam int LinkEnd = -2;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  rdata;
    logic [14:0] pos;
    logic [14:0] size;
  } fs_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [4:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  fs_result_t expected_results[$];

  // predictor state
  int links[NBlk];
  logic [7:0] store[NBlk*BBytes];
  bit written[NBlk*BBytes];
  int starts[NFile];
  int sizes[NFile];
  int cur_file, cur_blk, hpos;

  always #2 clk_i = ~clk_i;

  fat_chain_file_engine DUT (.*);

  function automatic int link_next(int blk);
    if (blk < 0 || blk >= NBlk) return NoBlk;
    if (links[blk] < 0 || links[blk] >= NBlk) return NoBlk;
    return links[blk];
  endfunction

  function automatic int free_block_count();
    int n;
    n = 0;
    for (int i = 0; i < NBlk; i++) if (links[i] == LinkFree) n++;
    return n;
  endfunction

  // true when a read now would hit a store byte never written
  function automatic bit read_unwritten();
    if (hpos >= sizes[cur_file] || cur_blk < 0 || cur_blk >= NBlk) return 0;
    return !written[cur_blk*BBytes + hpos%BBytes];
  endfunction

  function automatic bit take_free_block();
    int i, tail, nx;
    for (i = 0; i < NBlk; i++) if (links[i] == LinkFree) break;
    if (i >= NBlk) return 0;
    links[i] = LinkEnd;
    tail = starts[cur_file];
    if (tail < 0 || tail >= NBlk) starts[cur_file] = i;
    else begin
      for (int s = 0; s < NBlk; s++) begin
        nx = links[tail];
        if (nx < 0 || nx >= NBlk || nx == i) break;
        tail = nx;
      end
      links[tail] = i;
    end
    cur_blk = i;
    return 1;
  endfunction

  // compute the result of one request and advance the engine image
  function automatic fs_result_t predict_request(logic [2:0] req, logic [3:0] idx,
      logic [7:0] wd, logic signed [15:0] off, logic [1:0] org);
    fs_result_t r;
    int target, hops;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_CLEAR: begin
        starts[idx] = NoBlk;
        sizes[idx] = 0;
        if (idx == cur_file) begin
          cur_blk = NoBlk;
          hpos = 0;
        end
      end
      REQ_OPEN: begin
        cur_file = idx;
        cur_blk = starts[idx];
        hpos = 0;
      end
      REQ_WRITE: begin
        if ((cur_blk < 0 || cur_blk >= NBlk) && !take_free_block()) r.status = ST_NO_FREE;
        else begin
          store[cur_blk*BBytes + hpos%BBytes] = wd;
          written[cur_blk*BBytes + hpos%BBytes] = 1'b1;
          hpos++;
          if (sizes[cur_file] < SizeCap) sizes[cur_file]++;
          if (hpos % BBytes == 0) cur_blk = link_next(cur_blk);
        end
      end
      REQ_READ: begin
        if (hpos >= sizes[cur_file] || cur_blk < 0 || cur_blk >= NBlk) r.status = ST_EOF;
        else begin
          r.rdata = store[cur_blk*BBytes + hpos%BBytes];
          hpos++;
          if (hpos % BBytes == 0) cur_blk = link_next(cur_blk);
        end
      end
      REQ_SEEK: begin
        case (org)
          ORG_START: target = int'(off);
          ORG_CUR: target = hpos + int'(off);
          ORG_END: target = sizes[cur_file] + int'(off);
          default: target = -1;
        endcase
        if (org == ORG_BAD) r.status = ST_BAD_ORG;
        else if (target < 0 || target > sizes[cur_file]) r.status = ST_BAD_POS;
        else begin
          hpos = target;
          cur_blk = starts[cur_file];
          if (cur_blk < 0 || cur_blk >= NBlk) cur_blk = NoBlk;
          hops = hpos / BBytes;
          for (int k = 0; k < hops && cur_blk != NoBlk; k++) cur_blk = link_next(cur_blk);
        end
      end
      default: ;
    endcase
    r.pos = hpos[14:0];
    r.size = sizes[cur_file][14:0];
    return r;
  endfunction

  // drive one item and wait for acceptance
  task automatic send_request(logic [2:0] req, logic [3:0] idx = 0, logic [7:0] wd = 0,
      logic [15:0] off = 0, logic [1:0] org = ORG_START);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'b0, off, wd, idx};
    s_axis_tuser_i <= {org, req};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_results.push_back(predict_request(req, idx, wd, off, org));
  endtask

  // drop valid and wait for every expected result
  task automatic drain_results();
    if (s_axis_tvalid_i) s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // receiver stall and result comparison
  always @(posedge clk_i) begin
    fs_result_t got, exp_r;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = {m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[22:8],
               m_axis_tdata_o[37:23]};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0d rd=%h pos=%0d size=%0d %s",
                exp_r.status, exp_r.rdata, exp_r.pos, exp_r.size,
                $sformatf("got st=%0d rd=%h pos=%0d size=%0d",
                  got.status, got.rdata, got.pos, got.size));
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    send_request(REQ_READ);
    send_request(REQ_SEEK, 0, 0, 16'd1, ORG_START);
    send_request(REQ_WRITE, 0, 8'hFF);
    send_request(REQ_WRITE, 0, 8'h00);
    send_request(REQ_SEEK, 0, 0, 16'hFFFF, ORG_END);
    send_request(REQ_READ);
    send_request(REQ_READ);
    send_request(REQ_SEEK, 0, 0, 16'h7FFF, ORG_CUR);
    send_request(REQ_SEEK, 0, 0, 16'h8000, ORG_START);
    send_request(REQ_SEEK, 0, 0, 16'd0, ORG_BAD);
    send_request(REQ_OPEN, 4'd15);
    for (int i = 0; i < 64; i++) send_request(REQ_WRITE, 15, 8'(i));
    send_request(REQ_READ);
    send_request(REQ_SEEK, 15, 0, 16'd0, ORG_START);
    send_request(REQ_READ);
    send_request(REQ_CLEAR, 4'd15);
    send_request(REQ_CLEAR, 4'd3);
    send_request(REQ_OPEN, 4'd0);
    send_request(3'd5, 4'hF, 8'hAA, 16'h5555, 2'd3);
    send_request(3'd7);
    drain_results();
  endtask

  task automatic test_random(int n);
    logic [2:0] req;
    int open_idx;
    for (int i = 0; i < n; i++) begin
      req = 3'($urandom_range(99) < 40 ? REQ_WRITE : $urandom_range(99) < 50 ? REQ_READ
            : $urandom_range(7));
      open_idx = $urandom_range(3);
      case (req)
        REQ_CLEAR: if ($urandom_range(3) != 0) req = REQ_SEEK;
        REQ_SEEK: if ($urandom_range(3) == 0) begin
          send_request(REQ_SEEK, 0, 0, 16'($urandom), 2'($urandom));
          continue;
        end
        default: ;
      endcase
      if (req == REQ_READ && read_unwritten())
        send_request(REQ_SEEK, 0, 0, 16'd0, ORG_END);
      else if (req == REQ_SEEK)
        send_request(REQ_SEEK, 0, 0, 16'($signed($urandom_range(160)) - 80),
                     2'($urandom_range(2)));
      else if (req == REQ_CLEAR || req == REQ_OPEN)
        send_request(req, ($urandom_range(9) == 0) ? 4'($urandom) : 4'(open_idx));
      else send_request(req, 4'($urandom), 8'($urandom));
      if (i == n / 2) drain_results();
    end
  endtask

  task automatic test_block_exhaustion();
    send_request(REQ_OPEN, 4'd9);
    send_request(REQ_SEEK, 9, 0, 16'(BBytes * 300), ORG_START);
    send_request(REQ_SEEK, 9, 0, 16'd0, ORG_END);
    while (free_block_count() > 0) begin
      send_request(REQ_CLEAR, 4'd9);
      send_request(REQ_WRITE, 9, 8'($urandom));
    end
    send_request(REQ_CLEAR, 4'd9);
    send_request(REQ_WRITE, 9, 8'($urandom));
    send_request(REQ_READ);
    send_request(REQ_WRITE, 9, 8'($urandom));
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < NBlk; i++) links[i] = LinkFree;
    foreach (store[i]) store[i] = 8'h00;
    for (int i = 0; i < NFile; i++) begin
      starts[i] = NoBlk;
      sizes[i] = 0;
    end
    cur_file = 0;
    cur_blk = NoBlk;
    hpos = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 50;
    test_random(50);
    send_idle_pct = 0;
    recv_stall_pct = 50;
    test_random(50);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    test_random(50);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(50);
    test_block_exhaustion();
    drain_results();
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
